// ----- hdl/mqsb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqsb_pkg: shared types and constants for the multi-queue shared buffer
// Request and response payloads, status codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int QID_W   = 2;
  localparam int NUM_QID = 2 ** QID_W;
  localparam int DATA_W  = 32;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_WORD = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                     command;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ENQ_LINK,
    S_ENQ_TAIL,
    S_DEQ_READ,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic latch;
    logic lookup;
    logic enq_alloc;
    logic enq_tail;
    logic deq_pop;
    logic load_rsp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic refuse;
    logic queue_empty;
  } dp_status_t;

endpackage

// ----- hdl/multi_queue_shared_buffer.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several FIFO queues sharing one slot store
// Each request passes through lookup and then, as it needs, link, tail or
// dequeue-read steps; its response is loaded once the output is free, and a
// new request is taken only after that. Reset empties every queue and frees
// every slot at once.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer #(
  parameter int NUM_QUEUES = 4,
  parameter int NUM_SLOTS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mqsb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mqsb_pkg::rsp_t rsp
);

  mqsb_pkg::ctrl_cmd_t  cmd;
  mqsb_pkg::dp_status_t st;

  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mqsb_dp #(.NUM_QUEUES(NUM_QUEUES), .NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .st  (st),
    .rsp (rsp)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while another is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == mqsb_pkg::ST_OK || rsp.status == mqsb_pkg::ST_OVERFLOW
                   || rsp.status == mqsb_pkg::ST_UNDERFLOW))
    else $error("response carries an unknown status");

  a_underflow_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == mqsb_pkg::ST_UNDERFLOW) |-> rsp.data_out == mqsb_pkg::EMPTY_WORD)
    else $error("underflow response without the empty word");

endmodule

// ----- hdl/mqsb_ram.sv -----
// ----------------------------------------------------------------------------
// mqsb_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mqsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mqsb_ctrl: sequencing state machine
// Steps each request through lookup, link/pointer updates and response load;
// owns the request stall and the response valid flag.
// ----------------------------------------------------------------------------
module mqsb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  mqsb_pkg::dp_status_t st,
  output mqsb_pkg::ctrl_cmd_t  cmd
);

  mqsb_pkg::state_t state, state_next;
  logic             rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != mqsb_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mqsb_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mqsb_pkg::S_IDLE: begin
        if (req_valid) state_next = mqsb_pkg::S_LOOKUP;
      end
      mqsb_pkg::S_LOOKUP: begin
        if (st.refuse)      state_next = mqsb_pkg::S_RESULT;
        else if (st.is_deq) state_next = mqsb_pkg::S_DEQ_READ;
        else                state_next = mqsb_pkg::S_ENQ_LINK;
      end
      mqsb_pkg::S_ENQ_LINK: begin
        state_next = st.queue_empty ? mqsb_pkg::S_RESULT : mqsb_pkg::S_ENQ_TAIL;
      end
      mqsb_pkg::S_ENQ_TAIL: state_next = mqsb_pkg::S_RESULT;
      mqsb_pkg::S_DEQ_READ: state_next = mqsb_pkg::S_RESULT;
      mqsb_pkg::S_RESULT: begin
        if (rsp_free) state_next = mqsb_pkg::S_IDLE;
      end
      default: state_next = mqsb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      mqsb_pkg::S_IDLE:     cmd.latch     = req_valid;
      mqsb_pkg::S_LOOKUP:   cmd.lookup    = 1'b1;
      mqsb_pkg::S_ENQ_LINK: cmd.enq_alloc = 1'b1;
      mqsb_pkg::S_ENQ_TAIL: cmd.enq_tail  = 1'b1;
      mqsb_pkg::S_DEQ_READ: cmd.deq_pop   = 1'b1;
      mqsb_pkg::S_RESULT:   cmd.load_rsp  = rsp_free;
      default:              cmd           = '0;
    endcase
  end

endmodule

// ----- hdl/mqsb_dp.sv -----
// ----------------------------------------------------------------------------
// mqsb_dp: queue pointers, free list and slot stores
// Slot data and slot links live in RAMs; queue heads/tails, the free-list
// head and the fill count are registers.
// ----------------------------------------------------------------------------
module mqsb_dp #(
  parameter int NUM_QUEUES = 4,
  parameter int NUM_SLOTS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mqsb_pkg::req_t       req,
  input  mqsb_pkg::ctrl_cmd_t  cmd,
  output mqsb_pkg::dp_status_t st,
  output mqsb_pkg::rsp_t       rsp
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam logic [LW-1:0] LIST_END = LW'(NUM_SLOTS);

  // latched request
  logic                                cur_cmd;
  logic [mqsb_pkg::QID_W-1:0]          cur_q;
  logic signed [mqsb_pkg::DATA_W-1:0]  cur_val;

  logic [LW-1:0] queue_head [mqsb_pkg::NUM_QID];
  logic [IW-1:0] queue_tail [mqsb_pkg::NUM_QID];
  logic [LW-1:0] free_head;
  logic [LW-1:0] fill;   // slots at or above this were never handed out
  logic [IW-1:0] slot;

  logic [1:0]                         pend_status;
  logic signed [mqsb_pkg::DATA_W-1:0] pend_data;

  logic [LW-1:0] head_q;
  logic          q_ok;
  logic          is_deq;

  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;
  logic [IW-1:0] rd_addr;
  logic [LW-1:0] link_rd;
  logic [mqsb_pkg::DATA_W-1:0] data_rd;

  assign head_q = queue_head[cur_q];
  assign q_ok   = int'(cur_q) < NUM_QUEUES;
  assign is_deq = (cur_cmd == mqsb_pkg::CMD_DEQ);

  assign st.is_deq      = is_deq;
  assign st.queue_empty = (head_q == LIST_END);
  assign st.refuse      = !q_ok || (is_deq ? (head_q == LIST_END) : (free_head == LIST_END));

  assign rd_addr = is_deq ? head_q[IW-1:0] : free_head[IW-1:0];

  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = LIST_END;
    priority if (cmd.enq_alloc) begin
      link_we = 1'b1;
    end else if (cmd.enq_tail) begin
      link_we    = 1'b1;
      link_waddr = queue_tail[cur_q];
      link_wdata = LW'(slot);
    end else if (cmd.deq_pop) begin
      link_we    = 1'b1;
      link_wdata = free_head;
    end else begin
      link_we = 1'b0;
    end
  end

  mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  mqsb_ram #(.WIDTH(mqsb_pkg::DATA_W), .DEPTH(NUM_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (cmd.enq_alloc),
    .waddr (slot),
    .wdata (cur_val),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < mqsb_pkg::NUM_QID; i++) begin
        queue_head[i] <= LIST_END;
      end
    end else begin
      if (cmd.enq_alloc) begin
        if (free_head == fill) begin
          free_head <= free_head + LW'(1);
          fill      <= fill + LW'(1);
        end else begin
          free_head <= link_rd;
        end
        if (head_q == LIST_END) queue_head[cur_q] <= LW'(slot);
      end
      if (cmd.deq_pop) begin
        queue_head[cur_q] <= link_rd;
        free_head         <= LW'(slot);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_cmd <= req.command;
      cur_q   <= req.queue_id;
      cur_val <= req.value;
    end
    if (cmd.lookup) begin
      slot <= rd_addr;
      if (is_deq) begin
        pend_status <= mqsb_pkg::ST_UNDERFLOW;
        pend_data   <= mqsb_pkg::EMPTY_WORD;
      end else begin
        pend_status <= mqsb_pkg::ST_OVERFLOW;
        pend_data   <= '0;
      end
    end
    if (cmd.enq_alloc) begin
      // a non-empty queue keeps its old tail until the tail link is written
      if (head_q == LIST_END) queue_tail[cur_q] <= slot;
      pend_status <= mqsb_pkg::ST_OK;
      pend_data   <= '0;
    end
    if (cmd.enq_tail) begin
      queue_tail[cur_q] <= slot;
    end
    if (cmd.deq_pop) begin
      pend_status <= mqsb_pkg::ST_OK;
      pend_data   <= data_rd;
    end
    if (cmd.load_rsp) begin
      rsp.status   <= pend_status;
      rsp.data_out <= pend_data;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for multi_queue_shared_buffer
// A directed table (empty queues, value extremes, filling the store to overflow)
// is followed by random enqueue/dequeue traffic with a shifting enqueue bias.
// Every response is checked in order against the table or a free-list model.
// Both sides stall at random; the bench also pauses until all responses drain.
// ----------------------------------------------------------------------------
module tb;

  localparam int NQ          = 4;
  localparam int NS          = 16;
  localparam logic [4:0] END_MARK = 5'd16;
  localparam int PHASE_ITEMS = 267;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    mqsb_pkg::req_t rq;
    bit             typed;
    mqsb_pkg::rsp_t want;
  } dir_row_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  mqsb_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  mqsb_pkg::rsp_t rsp;

  // model state
  logic signed [mqsb_pkg::DATA_W-1:0] store_word [NS];
  logic [4:0]                         next_slot  [NS];
  logic [4:0]                         q_first    [NQ];
  logic [3:0]                         q_last     [NQ];
  logic [4:0]                         free_top;

  mqsb_pkg::rsp_t pending_rsp [$];
  dir_row_t       dir_rows [$];
  int             fault_count   = 0;
  int             send_idle_pct = 38;
  int             recv_idle_pct = 79;

  multi_queue_shared_buffer #(
    .NUM_QUEUES(NQ),
    .NUM_SLOTS (NS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_fault(input string text);
    fault_count++;
    if (fault_count <= 10) $display("ERROR: %s", text);
  endtask

  function automatic void buffer_clear();
    for (int i = 0; i < NS; i++) begin
      store_word[i] = '0;
      next_slot[i]  = 5'(i + 1);
    end
    for (int i = 0; i < NQ; i++) begin
      q_first[i] = END_MARK;
      q_last[i]  = '0;
    end
    free_top = '0;
  endfunction

  function automatic mqsb_pkg::rsp_t buffer_predict(input mqsb_pkg::req_t r);
    mqsb_pkg::rsp_t o;
    logic [4:0]     s;
    logic [4:0]     h;
    int             qid;
    qid        = int'(r.queue_id);
    o.status   = mqsb_pkg::ST_OK;
    o.data_out = '0;
    if (r.command == mqsb_pkg::CMD_ENQ) begin
      s = free_top;
      if (qid >= NQ || s >= END_MARK) begin
        o.status = mqsb_pkg::ST_OVERFLOW;
      end else begin
        free_top = next_slot[s[3:0]];
        if (q_first[qid] >= END_MARK) q_first[qid] = s;
        else next_slot[q_last[qid]] = s;
        next_slot[s[3:0]]  = END_MARK;
        q_last[qid]        = s[3:0];
        store_word[s[3:0]] = r.value;
      end
    end else begin
      h = (qid < NQ) ? q_first[qid] : END_MARK;
      if (h >= END_MARK) begin
        o.status   = mqsb_pkg::ST_UNDERFLOW;
        o.data_out = mqsb_pkg::EMPTY_WORD;
      end else begin
        q_first[qid]      = next_slot[h[3:0]];
        next_slot[h[3:0]] = free_top;
        free_top          = h;
        o.data_out        = store_word[h[3:0]];
      end
    end
    return o;
  endfunction

  function automatic dir_row_t mk_row(input logic cmd, input logic [1:0] qid,
                                      input logic signed [mqsb_pkg::DATA_W-1:0] val,
                                      input bit typed, input logic [1:0] st,
                                      input logic signed [mqsb_pkg::DATA_W-1:0] dat);
    dir_row_t row;
    row.rq.command     = cmd;
    row.rq.queue_id    = qid;
    row.rq.value       = val;
    row.typed          = typed;
    row.want.status    = st;
    row.want.data_out  = dat;
    return row;
  endfunction

  // present one request, hold it until taken, then maybe idle a while
  task automatic send_req(input mqsb_pkg::req_t r, input bit typed,
                          input mqsb_pkg::rsp_t want);
    mqsb_pkg::rsp_t pred;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = buffer_predict(r);
    pending_rsp.push_back(typed ? want : pred);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // response side: check in order, stall at random
  always @(posedge clk) begin
    mqsb_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        log_fault($sformatf("response with none outstanding: status %0d data %0d",
                            rsp.status, rsp.data_out));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.data_out !== want.data_out)
          log_fault($sformatf("status exp %0d got %0d, data exp %0d (%h) got %0d (%h)",
                              want.status, rsp.status, want.data_out, want.data_out,
                              rsp.data_out, rsp.data_out));
      end
    end
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("multi_queue_shared_buffer verification failed");
    $finish;
  end

  initial begin
    mqsb_pkg::req_t                     r;
    mqsb_pkg::rsp_t                     none;
    int                                 enq_bias;
    int                                 focus_q;
    logic signed [mqsb_pkg::DATA_W-1:0] v;
    logic signed [mqsb_pkg::DATA_W-1:0] fill_val [16];

    none      = '0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    buffer_clear();

    fill_val[0]  = 32'sh8000_0000;
    fill_val[1]  = 32'sh7FFF_FFFF;
    fill_val[2]  = 32'sh0000_0000;
    fill_val[3]  = -32'sd1;
    fill_val[4]  = 32'sh0000_0001;
    fill_val[5]  = 32'sh5555_5555;
    fill_val[6]  = 32'shAAAA_AAAA;
    fill_val[7]  = 32'sh0000_FFFF;
    fill_val[8]  = 32'shFFFF_0000;
    fill_val[9]  = 32'sh1234_5678;
    for (int i = 10; i < 16; i++) fill_val[i] = $urandom;

    // empty queues answer underflow
    for (int q = 0; q < NQ; q++)
      dir_rows.push_back(mk_row(mqsb_pkg::CMD_DEQ, 2'(q), $urandom, 1'b1,
                                mqsb_pkg::ST_UNDERFLOW, mqsb_pkg::EMPTY_WORD));
    // take every slot, spread over all queues, then one too many
    for (int i = 0; i < NS; i++)
      dir_rows.push_back(mk_row(mqsb_pkg::CMD_ENQ, 2'(i % NQ), fill_val[i], 1'b1,
                                mqsb_pkg::ST_OK, '0));
    dir_rows.push_back(mk_row(mqsb_pkg::CMD_ENQ, 2'd2, 32'sh7FFF_FFFF, 1'b1,
                              mqsb_pkg::ST_OVERFLOW, '0));
    dir_rows.push_back(mk_row(mqsb_pkg::CMD_DEQ, 2'd0, '0, 1'b0, mqsb_pkg::ST_OK, '0));
    dir_rows.push_back(mk_row(mqsb_pkg::CMD_DEQ, 2'd1, -32'sd1, 1'b0, mqsb_pkg::ST_OK, '0));
    dir_rows.push_back(mk_row(mqsb_pkg::CMD_DEQ, 2'd3, '0, 1'b0, mqsb_pkg::ST_OK, '0));
    dir_rows.push_back(mk_row(mqsb_pkg::CMD_DEQ, 2'd0, '0, 1'b0, mqsb_pkg::ST_OK, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      drain_wait();
      case (ph)
        0: begin send_idle_pct = 38; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_wait();
        // swing occupancy between full and empty in blocks
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0: enq_bias = 85;
            1: enq_bias = 50;
            default: enq_bias = 15;
          endcase
          focus_q = $urandom_range(NQ - 1);
        end
        case ($urandom_range(7))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          3: v = -32'sd1;
          default: v = $urandom;
        endcase
        r.command  = ($urandom_range(99) < enq_bias) ? mqsb_pkg::CMD_ENQ : mqsb_pkg::CMD_DEQ;
        r.queue_id = ($urandom_range(99) < 60) ? 2'(focus_q) : 2'($urandom_range(NQ - 1));
        r.value    = v;
        send_req(r, 1'b0, none);
      end
    end

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_rsp.size() != 0)
      log_fault($sformatf("%0d responses never arrived", pending_rsp.size()));

    if (fault_count == 0) $display("multi_queue_shared_buffer verification clean");
    else $display("multi_queue_shared_buffer verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mqsb_pkg.sv
hdl/mqsb_ram.sv
hdl/mqsb_ctrl.sv
hdl/mqsb_dp.sv
hdl/multi_queue_shared_buffer.sv
verif/tb.sv
